// File: hdl/spims_pkg.sv
// ----------------------------------------------------------------------------
// spims_pkg
// Shared types and constants for the SPI master word shifter.
// ----------------------------------------------------------------------------
package spims_pkg;

    // Default shift width
    localparam int SPIMS_WORD_BITS = 8;

    // Request codes carried in func
    localparam logic [1:0] FUNC_TICK       = 2'd0;
    localparam logic [1:0] FUNC_WRITE_READ = 2'd1;
    localparam logic [1:0] FUNC_READ_ONLY  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_CLOCK_POLARITY = 2'd0;
    localparam logic [1:0] CFG_CLOCK_PHASE    = 2'd1;
    localparam logic [1:0] CFG_HALF_PERIOD    = 2'd2;

    // Configuration reset values
    localparam logic       CPOL_RESET        = 1'b1;
    localparam logic       CPHA_RESET        = 1'b1;
    localparam logic [7:0] HALF_PERIOD_RESET = 8'd2;

    // Input request payload
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] tx_byte;
        logic       miso;
    } in_item_t;

    // Result payload
    typedef struct packed {
        logic       sck;
        logic       mosi;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
    } out_item_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic       clock_polarity;
        logic       clock_phase;
        logic [7:0] half_period;
    } spims_cfg_t;

endpackage

// File: hdl/spims_in_reg.sv
// ----------------------------------------------------------------------------
// spims_in_reg
// Input register stage: captures one request per cycle while load is high.
// ----------------------------------------------------------------------------
module spims_in_reg
    import spims_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  logic     drain,
    input  in_item_t item_in,
    output logic     valid,
    output in_item_t item_out
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign valid_next = load ? 1'b1 : (drain ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

endmodule

// File: hdl/spims_core.sv
// ----------------------------------------------------------------------------
// spims_core
// Bus state and one-tick step logic for the SPI master.
// ----------------------------------------------------------------------------
module spims_core
    import spims_pkg::*;
#(
    parameter int WORD_BITS = SPIMS_WORD_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  spims_cfg_t cfg,
    input  logic       fire,
    input  in_item_t   item,
    output out_item_t  result
);

    localparam int BLW = $clog2(WORD_BITS + 1);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SETUP  = 2'd1;
    localparam logic [1:0] PH_SAMPLE = 2'd2;

    logic [WORD_BITS-1:0] shift_word_reg, shift_word_next;
    logic [BLW-1:0]       bits_left_reg, bits_left_next;
    logic [1:0]           phase_step_reg, phase_step_next;
    logic [7:0]           wait_count_reg, wait_count_next;
    logic                 clock_level_reg, clock_level_next;
    logic                 out_level_reg, out_level_next;
    logic                 read_only_flag_reg, read_only_flag_next;

    logic [7:0]           ph_len;
    logic [7:0]           wc_dec;
    logic [BLW-1:0]       bl_dec;
    logic                 do_setup;
    logic                 done;
    logic [WORD_BITS+7:0] rx_ext;
    logic [WORD_BITS+7:0] tx_ext;

    assign tx_ext = {{WORD_BITS{1'b0}}, item.tx_byte};

    always_comb
    begin
        ph_len = (cfg.half_period == 8'd0) ? 8'd1 : cfg.half_period;
        wc_dec = (wait_count_reg != 8'd0) ? wait_count_reg - 8'd1 : 8'd0;
        bl_dec = (bits_left_reg != '0) ? bits_left_reg - BLW'(1) : '0;

        shift_word_next     = shift_word_reg;
        bits_left_next      = bits_left_reg;
        phase_step_next     = phase_step_reg;
        wait_count_next     = wait_count_reg;
        clock_level_next    = clock_level_reg;
        out_level_next      = out_level_reg;
        read_only_flag_next = read_only_flag_reg;
        do_setup            = 1'b0;
        done                = 1'b0;
        rx_ext              = '0;

        case (phase_step_reg)
            PH_SETUP:
            begin
                wait_count_next = wc_dec;
                if (wc_dec == 8'd0)
                begin
                    // sampling edge
                    clock_level_next = ~clock_level_reg;
                    shift_word_next  = {shift_word_reg[WORD_BITS-1:1],
                                        shift_word_reg[0] | item.miso};
                    bits_left_next   = bl_dec;
                    if (bl_dec == '0)
                    begin
                        done   = 1'b1;
                        rx_ext = {8'd0, shift_word_next};
                    end
                    phase_step_next = PH_SAMPLE;
                    wait_count_next = ph_len;
                end
            end
            PH_SAMPLE:
            begin
                wait_count_next = wc_dec;
                if (wc_dec == 8'd0)
                begin
                    if (bits_left_reg == '0)
                    begin
                        phase_step_next  = PH_IDLE;
                        clock_level_next = cfg.clock_polarity;
                    end
                    else
                    begin
                        do_setup = 1'b1;
                    end
                end
            end
            default:
            begin
                // idle, and the unused code behaves the same
                phase_step_next  = PH_IDLE;
                clock_level_next = cfg.clock_polarity;
                if (item.func inside {FUNC_WRITE_READ, FUNC_READ_ONLY})
                begin
                    read_only_flag_next = (item.func == FUNC_READ_ONLY);
                    shift_word_next     = read_only_flag_next ? '0
                                          : tx_ext[WORD_BITS-1:0];
                    bits_left_next      = BLW'(WORD_BITS);
                    do_setup            = 1'b1;
                end
            end
        endcase

        if (do_setup)
        begin
            // setup phase: drive next bit, SCK to its leading level
            if (!read_only_flag_next)
            begin
                out_level_next = shift_word_next[WORD_BITS-1];
            end
            shift_word_next  = {shift_word_next[WORD_BITS-2:0], 1'b0};
            clock_level_next = cfg.clock_phase ? ~cfg.clock_polarity
                                               : cfg.clock_polarity;
            phase_step_next  = PH_SETUP;
            wait_count_next  = ph_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_word_reg     <= '0;
            bits_left_reg      <= '0;
            phase_step_reg     <= PH_IDLE;
            wait_count_reg     <= 8'd0;
            clock_level_reg    <= CPOL_RESET;
            out_level_reg      <= 1'b0;
            read_only_flag_reg <= 1'b0;
        end
        else if (fire)
        begin
            shift_word_reg     <= shift_word_next;
            bits_left_reg      <= bits_left_next;
            phase_step_reg     <= phase_step_next;
            wait_count_reg     <= wait_count_next;
            clock_level_reg    <= clock_level_next;
            out_level_reg      <= out_level_next;
            read_only_flag_reg <= read_only_flag_next;
        end
    end

    always_comb
    begin
        result.sck      = clock_level_next;
        result.mosi     = out_level_next;
        result.busy_res = (phase_step_next != PH_IDLE);
        result.done_res = done;
        result.rx_byte  = rx_ext[7:0];
    end

endmodule

// File: hdl/spims_out_reg.sv
// ----------------------------------------------------------------------------
// spims_out_reg
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module spims_out_reg
    import spims_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  logic      stall,
    input  out_item_t item_in,
    output logic      valid,
    output out_item_t item_out
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign valid_next = load ? 1'b1 : (valid_reg && stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

endmodule

// File: hdl/spi_master_byte_shifter.sv
// A request accepted into the input register is stepped by the core into the result register.
// Throughput: one request per cycle unless stalled; the core step sits between the registers.
// in_stall rises only when both registers are full and the result is stalled.
// Reset (rst_n low, async): bus idle, SCK at 1, MOSI 0, CPOL 1, CPHA 1, half period 2.
// Configuration writes are always ready and apply to the next phase change.
// ----------------------------------------------------------------------------
// spi_master_byte_shifter
// SPI master shifting one word MSB first in any CPOL/CPHA mode, one timebase
// tick per request.
// ----------------------------------------------------------------------------
module spi_master_byte_shifter
    import spims_pkg::*;
#(
    parameter int WORD_BITS = SPIMS_WORD_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    // tick requests
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    // per-tick results
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data,
    // configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic       cpol_reg;
    logic       cpha_reg;
    logic [7:0] half_period_reg;
    spims_cfg_t cfg;

    logic       stage_valid;
    in_item_t   stage_item;
    logic       advance;     // result register can take a new value
    logic       fire;        // core steps on the staged request
    logic       accept;
    out_item_t  step_result;

    // Configuration registers; no back-pressure on this port.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpol_reg        <= CPOL_RESET;
            cpha_reg        <= CPHA_RESET;
            half_period_reg <= HALF_PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CLOCK_POLARITY: cpol_reg        <= cfg_data[0];
                CFG_CLOCK_PHASE:    cpha_reg        <= cfg_data[0];
                CFG_HALF_PERIOD:    half_period_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign cfg.clock_polarity = cpol_reg;
    assign cfg.clock_phase    = cpha_reg;
    assign cfg.half_period    = half_period_reg;

    // Flow control: a staged request moves on whenever the result register
    // is empty or being drained this cycle.
    assign advance  = !out_valid || !out_stall;
    assign fire     = stage_valid && advance;
    assign in_stall = stage_valid && !advance;
    assign accept   = in_valid && !in_stall;

    spims_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .drain    (fire),
        .item_in  (in_data),
        .valid    (stage_valid),
        .item_out (stage_item)
    );

    spims_core #(
        .WORD_BITS (WORD_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (fire),
        .item   (stage_item),
        .result (step_result)
    );

    spims_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .stall    (out_stall),
        .item_in  (step_result),
        .valid    (out_valid),
        .item_out (out_data)
    );

endmodule

// File: hdl/spims_checker.sv
// ----------------------------------------------------------------------------
// spims_checker
// Port-level checks for the SPI master, bound to the top level.
// ----------------------------------------------------------------------------
module spims_checker
    import spims_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // Requests are only held off while a result is waiting downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("request stalled with free result slot");

    // The last sample happens inside a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |-> out_data.busy_res)
        else $error("done outside transfer");

    // Received byte is zero except on the done tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.done_res |-> out_data.rx_byte == 8'd0)
        else $error("rx byte nonzero without done");

endmodule

bind spi_master_byte_shifter spims_checker u_spims_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
